/* rtl/bfa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap frame allocator package
// Map geometry, field widths, request kinds, status and register codes.
// ----------------------------------------------------------------------------
package bfa_pkg;

    localparam int FRAME_COUNT = 4096;
    localparam int LINE_BITS   = 64;
    localparam int MAP_LINES   = (FRAME_COUNT + LINE_BITS - 1) / LINE_BITS;
    localparam int LIDX_W      = (MAP_LINES > 1) ? $clog2(MAP_LINES) : 1;
    localparam int OFF_W       = $clog2(LINE_BITS);
    localparam int CHUNK_BITS  = (LINE_BITS < 16) ? LINE_BITS : 16;
    localparam int CHUNKS      = LINE_BITS / CHUNK_BITS;
    localparam int CIDX_W      = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
    localparam int COFF_W      = $clog2(CHUNK_BITS);
    localparam int FIDX_W      = $clog2(FRAME_COUNT);

    localparam int KIND_W      = 2;
    localparam int START_W     = 12;
    localparam int NUM_W       = 13;
    localparam int RANGE_W     = 13;
    localparam int CFG_IDX_W   = 1;

    localparam int WIDE_W      = ((FIDX_W + 1 > NUM_W) ? FIDX_W + 1 : NUM_W) + 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_ALLOC = 2'd0,
        KIND_FREE  = 2'd1,
        KIND_MARK  = 2'd2
    } t_kind;

    localparam logic ST_OK    = 1'b0;
    localparam logic ST_NOMEM = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_WIN_START = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_END = 1'd1;

endpackage

/* rtl/bfa_ifs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap frame allocator channels
// Request, response and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bfa_req_if;
    import bfa_pkg::*;
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [START_W-1:0]  base_frame;
    logic [NUM_W-1:0]    frame_cnt;
    modport source (output valid, kind, base_frame, frame_cnt, input ready);
    modport sink   (input valid, kind, base_frame, frame_cnt, output ready);
endinterface

interface bfa_rsp_if;
    import bfa_pkg::*;
    logic                valid;
    logic                ready;
    logic                status;
    logic [START_W-1:0]  run_start;
    logic [NUM_W-1:0]    run_length;
    modport source (output valid, status, run_start, run_length, input ready);
    modport sink   (input valid, status, run_start, run_length, output ready);
endinterface

interface bfa_cfg_if;
    import bfa_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [RANGE_W-1:0]   data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/bitmap_frame_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap frame allocator
// First-fit contiguous frame allocator over a one-bit-per-frame used map.
// ----------------------------------------------------------------------------
// The used map sits in a 64 x 64-bit synchronous RAM (one line per 64 frames)
// with a per-line valid bit, so it reads as all free right after reset with no
// clearing pass. One request word is taken at a time; the next is accepted as
// soon as the current result sits in the output register. Allocate scans 16
// frames per cycle from the window start, with the next line read overlapped
// with the last chunk of the current one, then writes the run back one line at
// a time, reading each line it touches and then modifying and writing it. Free
// and mark-allocated do the same read, then modify and write, for each line
// touched. Zero-frame and immediately failing requests go straight to the
// output register. Register writes are always taken and apply to the next
// request.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator (
    input  logic  i_clk,
    input  logic  i_rst_n,
    bfa_req_if.sink   i_req,
    bfa_rsp_if.source o_rsp,
    bfa_cfg_if.sink   i_cfg
);
    import bfa_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_SCAN_RD = 6'b000010,
        S_SCAN    = 6'b000100,
        S_WR_RD   = 6'b001000,
        S_WR      = 6'b010000,
        S_DONE    = 6'b100000
    } t_state;

    t_state                r_state,      n_state;
    logic [RANGE_W-1:0]    r_win_start;
    logic [RANGE_W-1:0]    r_range_end;
    logic [NUM_W-1:0]      r_n,          n_n;
    logic [WIDE_W-1:0]     r_rs,         n_rs;
    logic [WIDE_W-1:0]     r_end,        n_end;
    logic [WIDE_W-1:0]     r_lo,         n_lo;
    logic [WIDE_W-1:0]     r_hi,         n_hi;
    logic [LIDX_W-1:0]     r_line_idx,   n_line_idx;
    logic [CIDX_W-1:0]     r_chunk,      n_chunk;
    logic                  r_fresh,      n_fresh;
    logic                  r_set,        n_set;
    logic [LINE_BITS-1:0]  r_line,       n_line;
    logic                  r_status,     n_status;
    logic [START_W-1:0]    r_rstart,     n_rstart;
    logic [NUM_W-1:0]      r_rlen,       n_rlen;

    logic                  r_out_vld;
    logic                  r_out_status;
    logic [START_W-1:0]    r_out_start;
    logic [NUM_W-1:0]      r_out_len;

    logic [LINE_BITS-1:0]  mem [MAP_LINES];
    logic [MAP_LINES-1:0]  r_lvld;
    logic [LINE_BITS-1:0]  r_rdata;
    logic                  r_rd_vld;

    logic                  w_re;
    logic                  w_we;
    logic                  w_load;
    logic [LIDX_W-1:0]     w_raddr;
    logic [LINE_BITS-1:0]  w_mem_line;
    logic [LINE_BITS-1:0]  w_line;
    logic [CHUNK_BITS-1:0] w_chunk;
    logic [WIDE_W-1:0]     w_fbase;
    logic [WIDE_W-1:0]     w_f    [CHUNK_BITS];
    logic [WIDE_W-1:0]     w_rs   [CHUNK_BITS];
    logic [CHUNK_BITS-1:0] w_used;
    logic [CHUNK_BITS-1:0] w_succ;
    logic [CHUNK_BITS-1:0] w_fail;
    logic                  w_hit;
    logic                  w_hit_succ;
    logic [WIDE_W-1:0]     w_hit_f;
    logic [WIDE_W-1:0]     w_run_lo;
    logic [WIDE_W-1:0]     w_wbase;
    logic [LINE_BITS-1:0]  w_mask;
    logic [LINE_BITS-1:0]  w_wdata;
    logic                  w_wlast;
    logic                  w_last_chunk;
    logic [WIDE_W-1:0]     w_beg;
    logic [WIDE_W-1:0]     w_endc;
    logic [WIDE_W-1:0]     w_lo_in;
    logic [WIDE_W-1:0]     w_sum_in;
    logic [WIDE_W-1:0]     w_hi_in;

    assign i_req.ready      = (r_state == S_IDLE);
    assign i_cfg.ready      = 1'b1;
    assign o_rsp.valid      = r_out_vld;
    assign o_rsp.status     = r_out_status;
    assign o_rsp.run_start  = r_out_start;
    assign o_rsp.run_length = r_out_len;

    // Request decode
    assign w_beg    = WIDE_W'(r_win_start);
    assign w_endc   = (WIDE_W'(r_range_end) > WIDE_W'(FRAME_COUNT)) ?
                      WIDE_W'(FRAME_COUNT) : WIDE_W'(r_range_end);
    assign w_lo_in  = WIDE_W'(i_req.base_frame);
    assign w_sum_in = w_lo_in + WIDE_W'(i_req.frame_cnt);
    assign w_hi_in  = (w_sum_in > WIDE_W'(FRAME_COUNT)) ? WIDE_W'(FRAME_COUNT) : w_sum_in;

    // Scan datapath: one chunk of the current line per cycle
    assign w_mem_line   = r_rd_vld ? r_rdata : '0;
    assign w_line       = r_fresh ? w_mem_line : r_line;
    assign w_chunk      = w_line[int'(r_chunk) * CHUNK_BITS +: CHUNK_BITS];
    assign w_fbase      = (WIDE_W'(r_line_idx) << OFF_W) + (WIDE_W'(r_chunk) << COFF_W);
    assign w_last_chunk = (r_chunk == CIDX_W'(CHUNKS - 1));

    always_comb begin
        for (int k = 0; k < CHUNK_BITS; k++) begin
            w_f[k]    = w_fbase + WIDE_W'(k);
            w_used[k] = w_chunk[k] && (w_f[k] >= r_rs);
        end
        for (int k = 0; k < CHUNK_BITS; k++) begin
            w_rs[k] = r_rs;
            for (int j = 0; j <= k; j++) begin
                if (w_used[j]) begin
                    w_rs[k] = w_f[j] + WIDE_W'(1);
                end
            end
            w_fail[k] = (w_f[k] >= r_end);
            w_succ[k] = !w_used[k] && !w_fail[k] &&
                        (w_f[k] + WIDE_W'(1) >= w_rs[k] + WIDE_W'(r_n));
        end
        w_hit      = 1'b0;
        w_hit_succ = 1'b0;
        w_hit_f    = '0;
        for (int k = 0; k < CHUNK_BITS; k++) begin
            if (!w_hit && (w_succ[k] || w_fail[k])) begin
                w_hit      = 1'b1;
                w_hit_succ = w_succ[k];
                w_hit_f    = w_f[k];
            end
        end
    end

    assign w_run_lo = w_hit_f + WIDE_W'(1) - WIDE_W'(r_n);

    // Write datapath: set or clear the run's bits within one line
    assign w_wbase = WIDE_W'(r_line_idx) << OFF_W;
    assign w_wlast = (w_wbase + WIDE_W'(LINE_BITS) >= r_hi);

    always_comb begin
        for (int j = 0; j < LINE_BITS; j++) begin
            w_mask[j] = (w_wbase + WIDE_W'(j) >= r_lo) && (w_wbase + WIDE_W'(j) < r_hi);
        end
    end

    assign w_wdata = r_set ? (w_mem_line | w_mask) : (w_mem_line & ~w_mask);

    // Control
    always_comb begin
        n_state    = r_state;
        n_n        = r_n;
        n_rs       = r_rs;
        n_end      = r_end;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_line_idx = r_line_idx;
        n_chunk    = r_chunk;
        n_fresh    = r_fresh;
        n_set      = r_set;
        n_line     = r_line;
        n_status   = r_status;
        n_rstart   = r_rstart;
        n_rlen     = r_rlen;
        w_re       = 1'b0;
        w_we       = 1'b0;
        w_load     = 1'b0;
        w_raddr    = r_line_idx;

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_n      = i_req.frame_cnt;
                    n_end    = w_endc;
                    n_rs     = w_beg;
                    n_status = ST_OK;
                    n_rstart = '0;
                    n_rlen   = '0;
                    n_set    = 1'b1;
                    unique case (t_kind'(i_req.kind))
                        KIND_ALLOC: begin
                            if (i_req.frame_cnt == '0) begin
                                n_rstart = START_W'(r_win_start);
                                n_state  = S_DONE;
                            end else if (w_beg >= w_endc) begin
                                n_status = ST_NOMEM;
                                n_state  = S_DONE;
                            end else begin
                                n_line_idx = LIDX_W'(w_beg >> OFF_W);
                                n_chunk    = (CHUNKS > 1) ? CIDX_W'(w_beg >> COFF_W) : '0;
                                n_state    = S_SCAN_RD;
                            end
                        end
                        KIND_FREE, KIND_MARK: begin
                            n_set = (t_kind'(i_req.kind) == KIND_MARK);
                            n_lo  = w_lo_in;
                            n_hi  = w_hi_in;
                            if (w_hi_in > w_lo_in) begin
                                n_line_idx = LIDX_W'(w_lo_in >> OFF_W);
                                n_state    = S_WR_RD;
                            end else begin
                                n_state = S_DONE;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN_RD: begin
                w_re    = 1'b1;
                n_fresh = 1'b1;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                n_line  = w_line;
                n_fresh = 1'b0;
                if (w_hit) begin
                    if (w_hit_succ) begin
                        n_lo       = w_run_lo;
                        n_hi       = w_hit_f + WIDE_W'(1);
                        n_rstart   = START_W'(w_run_lo);
                        n_rlen     = r_n;
                        n_line_idx = LIDX_W'(w_run_lo >> OFF_W);
                        n_state    = S_WR_RD;
                    end else begin
                        n_status = ST_NOMEM;
                        n_state  = S_DONE;
                    end
                end else if (w_last_chunk) begin
                    if (r_line_idx == LIDX_W'(MAP_LINES - 1)) begin
                        n_status = ST_NOMEM;
                        n_state  = S_DONE;
                    end else begin
                        w_re       = 1'b1;
                        w_raddr    = r_line_idx + LIDX_W'(1);
                        n_line_idx = r_line_idx + LIDX_W'(1);
                        n_chunk    = '0;
                        n_fresh    = 1'b1;
                        n_rs       = w_rs[CHUNK_BITS-1];
                    end
                end else begin
                    n_chunk = r_chunk + CIDX_W'(1);
                    n_rs    = w_rs[CHUNK_BITS-1];
                end
            end
            S_WR_RD: begin
                w_re    = 1'b1;
                n_state = S_WR;
            end
            S_WR: begin
                w_we = 1'b1;
                if (w_wlast) begin
                    n_state = S_DONE;
                end else begin
                    n_line_idx = r_line_idx + LIDX_W'(1);
                    n_state    = S_WR_RD;
                end
            end
            S_DONE: begin
                if (!r_out_vld || o_rsp.ready) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_win_start <= '0;
            r_range_end <= '0;
            r_out_vld   <= 1'b0;
            r_lvld      <= '0;
            r_fresh     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fresh <= n_fresh;
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    REG_WIN_START: r_win_start <= i_cfg.data;
                    REG_RANGE_END: r_range_end <= i_cfg.data;
                    default:       r_range_end <= r_range_end;
                endcase
            end
            if (w_load) begin
                r_out_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
            if (w_we) begin
                r_lvld[r_line_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_n        <= n_n;
        r_rs       <= n_rs;
        r_end      <= n_end;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_line_idx <= n_line_idx;
        r_chunk    <= n_chunk;
        r_set      <= n_set;
        r_line     <= n_line;
        r_status   <= n_status;
        r_rstart   <= n_rstart;
        r_rlen     <= n_rlen;
        if (w_load) begin
            r_out_status <= r_status;
            r_out_start  <= r_rstart;
            r_out_len    <= r_rlen;
        end
    end

    // Used-map RAM
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[r_line_idx] <= w_wdata;
        end
        if (w_re) begin
            r_rdata  <= mem[w_raddr];
            r_rd_vld <= r_lvld[w_raddr];
        end
    end

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> (r_state != S_IDLE))
        else $error("accepted request did not start");

    a_nomem_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_status == ST_NOMEM) |-> (r_out_start == '0 && r_out_len == '0))
        else $error("failed allocation carries a run");

    a_scan_within_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_rs <= r_end))
        else $error("scan run start past range end");

    a_write_only_in_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_we && r_state == S_WR) |-> (r_lo < r_hi))
        else $error("line write with an empty run");

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap frame allocator testbench
// Drives allocate, free and mark-allocated words under several search windows
// and checks every response word against a frame-map model kept alongside.
// Both channels idle at random, the receiver stalls once for a long stretch.
// ----------------------------------------------------------------------------
module testbench;
    import bfa_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic               status;
        logic [START_W-1:0] run_start;
        logic [NUM_W-1:0]   run_length;
    } alloc_word_t;

    typedef struct {
        int unsigned first;
        int unsigned count;
    } frame_run_t;

    class alloc_tracker;
        bit [FRAME_COUNT-1:0] used_map;
        int unsigned          win_lo;
        int unsigned          win_hi;
        alloc_word_t          awaited_words[$];
        int                   errors;

        function new();
            used_map = '0;
            win_lo   = 0;
            win_hi   = 0;
            errors   = 0;
        endfunction

        function void write_range(logic [CFG_IDX_W-1:0] idx, logic [RANGE_W-1:0] data);
            if (idx == REG_WIN_START) begin
                win_lo = 32'(data);
            end else if (idx == REG_RANGE_END) begin
                win_hi = 32'(data);
            end
        endfunction

        function void paint(int unsigned first, int unsigned count, bit used);
            for (int unsigned j = 0; j < count; j++) begin
                if (first + j < FRAME_COUNT) begin
                    used_map[first + j] = used;
                end
            end
        endfunction

        function alloc_word_t note_request(logic [KIND_W-1:0] kind,
                                           logic [START_W-1:0] first,
                                           logic [NUM_W-1:0] count);
            alloc_word_t word;
            int unsigned lim;
            int unsigned s;
            int unsigned i;
            int unsigned n;
            bit          done;
            word = '{status: ST_OK, run_start: '0, run_length: '0};
            n = 32'(count);
            case (kind)
                KIND_ALLOC: begin
                    lim  = (win_hi > FRAME_COUNT) ? FRAME_COUNT : win_hi;
                    s    = win_lo;
                    done = 1'b0;
                    while (!done) begin
                        for (i = 0; i < n; i++) begin
                            if (s + i >= lim || used_map[s + i]) break;
                        end
                        if (i == n) begin
                            paint(s, n, 1'b1);
                            word.run_start  = s[START_W-1:0];
                            word.run_length = n[NUM_W-1:0];
                            done = 1'b1;
                        end else if (s + i >= lim) begin
                            word.status = ST_NOMEM;
                            done = 1'b1;
                        end else begin
                            s = s + i + 1;
                        end
                    end
                end
                KIND_FREE: paint(32'(first), n, 1'b0);
                KIND_MARK: paint(32'(first), n, 1'b1);
                default: ;
            endcase
            awaited_words.push_back(word);
            return word;
        endfunction

        function void check_word(logic got_status, logic [START_W-1:0] got_start,
                                 logic [NUM_W-1:0] got_length);
            alloc_word_t want;
            if (awaited_words.size() == 0) begin
                $error("response word with none awaited: status %0d start %0d length %0d",
                       got_status, got_start, got_length);
                errors++;
                return;
            end
            want = awaited_words.pop_front();
            if (got_status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, got_status);
                errors++;
            end
            if (got_start !== want.run_start) begin
                $error("run_start: expected %0d, actual %0d", want.run_start, got_start);
                errors++;
            end
            if (got_length !== want.run_length) begin
                $error("run_length: expected %0d, actual %0d", want.run_length, got_length);
                errors++;
            end
        endfunction

        function int pending();
            return awaited_words.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    bfa_req_if req_ch ();
    bfa_rsp_if rsp_ch ();
    bfa_cfg_if cfg_ch ();

    bitmap_frame_allocator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    alloc_tracker frame_map = new();
    frame_run_t   live_runs[$];
    int           send_idle_pct = 30;
    int           recv_idle_pct = 30;
    bit           hold_request  = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #30_000_000;
        $display("testbench failed");
        $finish;
    end

    initial begin : receiver
        rsp_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (600) @(posedge i_clk);
            end else begin
                rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            frame_map.check_word(rsp_ch.status, rsp_ch.run_start, rsp_ch.run_length);
        end
    end

    function automatic int unsigned pick_count();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 3) return 0;
        if (r < 70) return $urandom_range(1, 32);
        if (r < 90) return $urandom_range(33, 256);
        if (r < 98) return $urandom_range(257, 1024);
        return $urandom_range(1025, 4096);
    endfunction

    task automatic issue(input logic [KIND_W-1:0] kind, input int unsigned first,
                         input int unsigned count);
        alloc_word_t word;
        if ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.kind       <= kind;
        req_ch.base_frame <= first[START_W-1:0];
        req_ch.frame_cnt  <= count[NUM_W-1:0];
        do @(posedge i_clk); while (!req_ch.ready);
        word = frame_map.note_request(kind, first[START_W-1:0], count[NUM_W-1:0]);
        if (kind == KIND_ALLOC && word.status == ST_OK && word.run_length != 0) begin
            live_runs.push_back('{32'(word.run_start), 32'(word.run_length)});
        end
    endtask

    task automatic settle();
        req_ch.valid <= 1'b0;
        while (frame_map.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RANGE_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        frame_map.write_range(idx, data);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_window(input int unsigned lo, input int unsigned hi);
        settle();
        write_reg(REG_WIN_START, lo[RANGE_W-1:0]);
        write_reg(REG_RANGE_END, hi[RANGE_W-1:0]);
    endtask

    task automatic random_phase(input int items);
        int unsigned r;
        int unsigned pick;
        frame_run_t  run;
        repeat (items) begin
            r = $urandom_range(99);
            if (r < 45) begin
                issue(KIND_ALLOC, $urandom_range(4095), pick_count());
            end else if (r < 80 && live_runs.size() > 0) begin
                pick = $urandom_range(live_runs.size() - 1);
                run  = live_runs[pick];
                live_runs.delete(pick);
                issue(KIND_FREE, run.first, run.count);
            end else if (r < 88) begin
                issue(KIND_MARK, $urandom_range(4095), pick_count());
            end else if (r < 95) begin
                issue(KIND_FREE, $urandom_range(4095), pick_count());
            end else begin
                issue(KIND_W'($urandom_range(3)), $urandom_range(4095), $urandom_range(8191));
            end
        end
    endtask

    initial begin : stimulus
        i_rst_n           = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.kind       = KIND_ALLOC;
        req_ch.base_frame = '0;
        req_ch.frame_cnt  = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = REG_WIN_START;
        cfg_ch.data       = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        issue(KIND_ALLOC, 0, 0);
        issue(KIND_ALLOC, 0, 1);
        issue(KIND_UNUSED, 4095, 4096);

        set_window(0, 4096);
        issue(KIND_ALLOC, 4095, 1);
        issue(KIND_ALLOC, 0, 4096);
        issue(KIND_FREE, 0, 1);
        issue(KIND_ALLOC, 0, 4096);
        issue(KIND_ALLOC, 0, 1);
        issue(KIND_FREE, 4095, 4096);
        issue(KIND_ALLOC, 0, 1);
        issue(KIND_FREE, 0, 4096);
        issue(KIND_MARK, 100, 28);
        issue(KIND_ALLOC, 0, 100);
        issue(KIND_ALLOC, 0, 1);
        issue(KIND_MARK, 4000, 4096);
        issue(KIND_ALLOC, 0, 3872);
        issue(KIND_ALLOC, 0, 3871);
        issue(KIND_FREE, 0, 4096);
        issue(KIND_UNUSED, 0, 0);
        issue(KIND_MARK, 0, 0);

        set_window(4096, 4096);
        issue(KIND_ALLOC, 0, 0);
        issue(KIND_ALLOC, 0, 1);

        set_window(300, 100);
        issue(KIND_ALLOC, 0, 0);
        issue(KIND_ALLOC, 0, 5);

        set_window(4000, 4096);
        issue(KIND_ALLOC, 0, 96);
        issue(KIND_ALLOC, 0, 1);
        issue(KIND_FREE, 4000, 96);

        set_window(0, 4096);
        random_phase(400);

        settle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(250);

        set_window(64, 1000);
        send_idle_pct = 30;
        recv_idle_pct = 30;
        hold_request  = 1'b1;
        random_phase(300);

        set_window(1000, 1064);
        random_phase(250);

        set_window(4032, 4096);
        random_phase(200);

        set_window(7, 4095);
        random_phase(400);

        settle();
        repeat (300) @(posedge i_clk);
        if (frame_map.errors == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/bfa_pkg.sv
rtl/bfa_ifs.sv
rtl/bitmap_frame_allocator.sv
test/testbench.sv
